// File: hdl/stepper_burst_pulse_sequencer_defines.svh
// Assertion macros shared by the step pulse sequencer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STEPPER_BURST_PULSE_SEQUENCER_DEFINES_SVH
`define STEPPER_BURST_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbps check failed");

// Next-cycle implication, disabled during reset
`define SBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbps check failed");

`endif

// File: hdl/sbps_pkg.sv
// Shared types and constants for the step/dir burst pulse sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sbps_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MICROSTEPS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SETUP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_SETUP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_GAP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_HOLD   = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_MICROSTEPS   = 8'd100;
  localparam logic [15:0] RST_DIR_SETUP    = 16'd6;
  localparam logic [15:0] RST_ENABLE_SETUP = 16'd5;
  localparam logic [15:0] RST_PULSE_HIGH   = 16'd4;
  localparam logic [15:0] RST_PULSE_LOW    = 16'd4;
  localparam logic [15:0] RST_GROUP_GAP    = 16'd1500;
  localparam logic [15:0] RST_FINAL_HOLD   = 16'd5;

  // Input item kinds
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Input payload packing
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic [7:0]  microsteps_per_group;
    logic [15:0] dir_setup_ticks;
    logic [15:0] enable_setup_ticks;
    logic [15:0] pulse_high_ticks;
    logic [15:0] pulse_low_ticks;
    logic [15:0] group_gap_ticks;
    logic [15:0] final_hold_ticks;
  } sbps_cfg_t;

  typedef struct packed {
    logic start_rejected;
    logic done_res;
    logic busy_res;
    logic enable_level;
    logic dir_level;
    logic step_level;
  } sbps_res_t;

endpackage

`default_nettype wire

// File: hdl/stepper_burst_pulse_sequencer.sv
// An input transaction passes through the input register, then the result
// register, before its result transaction appears. Throughput: one
// transaction per cycle while out_tready accepts results; the phase state
// updates in a single pass per item. Reset: rst_n synchronous active low;
// phase idle, pins low, registers back to their default timings.
// Top level of the step/dir burst pulse sequencer; uses sbps_pkg,
// sbps_cfg_regs and sbps_core.
`timescale 1ns / 1ps
`default_nettype none

module stepper_burst_pulse_sequencer
  import sbps_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] direction, [24:1] step_count
  input  wire logic                   in_tuser,   // [0] mode
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [0] step_level, [1] dir_level,
                                                  // [2] enable_level, [3] busy_res,
                                                  // [4] done_res, [5] start_rejected
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_mode_r;
  logic        s1_dir_r;
  logic [23:0] s1_count_r;
  logic        in_take;
  logic        adv;
  logic        out_valid_r, out_valid_nxt;
  sbps_res_t   res;
  sbps_res_t   res_r;
  sbps_cfg_t   cfg;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  sbps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the input register into the result register when it has room
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_tuser;
      s1_dir_r   <= in_tdata[0];
      s1_count_r <= in_tdata[24:1];
    end
  end

  sbps_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_mode       (s1_mode_r),
    .in_direction  (s1_dir_r),
    .in_step_count (s1_count_r),
    .cfg           (cfg),
    .res           (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

`default_nettype wire

// File: hdl/sbps_cfg_regs.sv
// Configuration register file of the step pulse sequencer.
// Depends on sbps_pkg for register indexes, reset values and sbps_cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module sbps_cfg_regs
  import sbps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output sbps_cfg_t                  cfg
);

  sbps_cfg_t cfg_r;
  sbps_cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MICROSTEPS:   cfg_nxt.microsteps_per_group = wr_data[7:0];
        REG_DIR_SETUP:    cfg_nxt.dir_setup_ticks      = wr_data;
        REG_ENABLE_SETUP: cfg_nxt.enable_setup_ticks   = wr_data;
        REG_PULSE_HIGH:   cfg_nxt.pulse_high_ticks     = wr_data;
        REG_PULSE_LOW:    cfg_nxt.pulse_low_ticks      = wr_data;
        REG_GROUP_GAP:    cfg_nxt.group_gap_ticks      = wr_data;
        REG_FINAL_HOLD:   cfg_nxt.final_hold_ticks     = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.microsteps_per_group <= RST_MICROSTEPS;
      cfg_r.dir_setup_ticks      <= RST_DIR_SETUP;
      cfg_r.enable_setup_ticks   <= RST_ENABLE_SETUP;
      cfg_r.pulse_high_ticks     <= RST_PULSE_HIGH;
      cfg_r.pulse_low_ticks      <= RST_PULSE_LOW;
      cfg_r.group_gap_ticks      <= RST_GROUP_GAP;
      cfg_r.final_hold_ticks     <= RST_FINAL_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/sbps_core.sv
// Phase sequencer of the step pulse generator: state registers plus the
// single-pass next-state logic. Depends on sbps_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_burst_pulse_sequencer_defines.svh"

module sbps_core
  import sbps_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_mode,
  input  wire logic        in_direction,
  input  wire logic [23:0] in_step_count,
  input  wire sbps_cfg_t   cfg,
  output sbps_res_t        res
);

  // Phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DIR  = 3'd1;
  localparam logic [2:0] PH_EN   = 3'd2;
  localparam logic [2:0] PH_HIGH = 3'd3;
  localparam logic [2:0] PH_LOW  = 3'd4;
  localparam logic [2:0] PH_GAP  = 3'd5;
  localparam logic [2:0] PH_HOLD = 3'd6;

  localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  logic [2:0]            phase_r, phase_nxt;
  logic [15:0]           wait_r, wait_nxt;
  logic [COUNT_BITS-1:0] pl_r, pl_nxt;
  logic [7:0]            gp_r, gp_nxt;
  logic                  fg_r, fg_nxt;
  logic                  dir_r, dir_nxt;
  logic                  step_r, step_nxt;
  logic                  en_r, en_nxt;
  logic                  done_c, rej_c;

  logic [7:0]            grp_size;
  logic [15:0]           high_len, low_len, wait_dec;
  logic [31:0]           cnt_ext, cnt_sat;
  logic [COUNT_BITS-1:0] pl_load, pl_dec, bg_pl;
  logic                  bg_final;
  logic [7:0]            gp_dec;

  // Zero lengths and group size count as one
  assign grp_size = (cfg.microsteps_per_group == 8'd0) ? 8'd1 : cfg.microsteps_per_group;
  assign high_len = (cfg.pulse_high_ticks == 16'd0) ? 16'd1 : cfg.pulse_high_ticks;
  assign low_len  = (cfg.pulse_low_ticks == 16'd0) ? 16'd1 : cfg.pulse_low_ticks;

  // Saturate the requested count to the counter width
  assign cnt_ext = {8'd0, in_step_count};
  assign cnt_sat = (cnt_ext > CMAX) ? CMAX : cnt_ext;
  assign pl_load = cnt_sat[COUNT_BITS-1:0];

  assign pl_dec   = pl_r - COUNT_BITS'(1);
  assign gp_dec   = gp_r - 8'd1;
  assign wait_dec = (wait_r != 16'd0) ? (wait_r - 16'd1) : 16'd0;

  // Pulse count seen when a group begins on this item
  assign bg_pl    = (in_mode == MODE_START) ? pl_load :
                    ((phase_r == PH_LOW) ? pl_dec : pl_r);
  assign bg_final = bg_pl < COUNT_BITS'(grp_size);

  // Next-state logic for one transaction
  always_comb begin
    logic do_bg;
    do_bg     = 1'b0;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    pl_nxt    = pl_r;
    gp_nxt    = gp_r;
    fg_nxt    = fg_r;
    dir_nxt   = dir_r;
    step_nxt  = step_r;
    en_nxt    = en_r;
    done_c    = 1'b0;
    rej_c     = 1'b0;

    if (in_mode == MODE_START) begin
      if (phase_r != PH_IDLE) begin
        rej_c = 1'b1;
      end else begin
        dir_nxt  = in_direction;
        pl_nxt   = pl_load;
        step_nxt = 1'b0;
        en_nxt   = 1'b0;
        if (cfg.dir_setup_ticks == 16'd0) begin
          do_bg = 1'b1;
        end else begin
          phase_nxt = PH_DIR;
          wait_nxt  = cfg.dir_setup_ticks;
        end
      end
    end else if (phase_r != PH_IDLE && phase_r <= PH_HOLD) begin
      wait_nxt = wait_dec;
      if (wait_dec == 16'd0) begin
        unique case (phase_r) inside
          PH_DIR, PH_GAP: do_bg = 1'b1;
          PH_EN: begin
            phase_nxt = PH_HIGH;
            step_nxt  = 1'b1;
            wait_nxt  = high_len;
          end
          PH_HIGH: begin
            phase_nxt = PH_LOW;
            step_nxt  = 1'b0;
            wait_nxt  = low_len;
          end
          PH_LOW: begin
            gp_nxt = gp_dec;
            pl_nxt = pl_dec;
            if (gp_dec != 8'd0) begin
              phase_nxt = PH_HIGH;
              step_nxt  = 1'b1;
              wait_nxt  = high_len;
            end else begin
              en_nxt = 1'b0;
              if (fg_r) begin
                phase_nxt = PH_HOLD;
                wait_nxt  = cfg.final_hold_ticks;
                if (cfg.final_hold_ticks == 16'd0) begin
                  phase_nxt = PH_IDLE;
                  done_c    = 1'b1;
                end
              end else begin
                phase_nxt = PH_GAP;
                wait_nxt  = cfg.group_gap_ticks;
                if (cfg.group_gap_ticks == 16'd0) begin
                  do_bg = 1'b1;
                end
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            step_nxt  = 1'b0;
            en_nxt    = 1'b0;
            done_c    = 1'b1;
          end
        endcase
      end
    end

    // Begin a group, or finish when no pulses remain
    if (do_bg) begin
      if (bg_pl == '0) begin
        phase_nxt = PH_IDLE;
        wait_nxt  = 16'd0;
        step_nxt  = 1'b0;
        en_nxt    = 1'b0;
        done_c    = 1'b1;
      end else begin
        fg_nxt = bg_final;
        gp_nxt = bg_final ? bg_pl[7:0] : grp_size;
        en_nxt = 1'b1;
        if (cfg.enable_setup_ticks == 16'd0) begin
          phase_nxt = PH_HIGH;
          step_nxt  = 1'b1;
          wait_nxt  = high_len;
        end else begin
          phase_nxt = PH_EN;
          wait_nxt  = cfg.enable_setup_ticks;
        end
      end
    end
  end

  // Advance state once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wait_r  <= 16'd0;
      pl_r    <= '0;
      gp_r    <= 8'd0;
      fg_r    <= 1'b0;
      dir_r   <= 1'b0;
      step_r  <= 1'b0;
      en_r    <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      pl_r    <= pl_nxt;
      gp_r    <= gp_nxt;
      fg_r    <= fg_nxt;
      dir_r   <= dir_nxt;
      step_r  <= step_nxt;
      en_r    <= en_nxt;
    end
  end

  assign res.step_level     = step_nxt;
  assign res.dir_level      = dir_nxt;
  assign res.enable_level   = en_nxt;
  assign res.busy_res       = (phase_nxt != PH_IDLE);
  assign res.done_res       = done_c;
  assign res.start_rejected = rej_c;

  // Step and enable pins are quiet whenever no sequence runs
  `SBPS_ASSERT_NOW(a_idle_quiet, clk, rst_n, phase_r == PH_IDLE, !en_r && !step_r)
  // Step pin is high only in the high phase, with the driver enabled
  `SBPS_ASSERT_NOW(a_step_in_high, clk, rst_n, step_r, phase_r == PH_HIGH && en_r)
  // A rejected start leaves the running sequence untouched
  `SBPS_ASSERT_NEXT(a_rej_hold, clk, rst_n, adv && rej_c,
                    $stable(pl_r) && $stable(dir_r) && $stable(phase_r))
  // A tick while idle keeps the block idle
  `SBPS_ASSERT_NEXT(a_idle_tick, clk, rst_n,
                    adv && phase_r == PH_IDLE && in_mode == MODE_TICK, phase_r == PH_IDLE)

endmodule

`default_nettype wire
